FILE: sv/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
`default_nettype none

package bgc_pkg;

    localparam int unsigned TIME_W = 64;
    localparam int unsigned CFG_W  = 24;
    localparam int unsigned IDX_W  = 2;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SINGLE = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } t_gesture;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_SHORT_MIN = 2'd1,
        CFG_LONG_MIN  = 2'd2,
        CFG_DBL_WIN   = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 24'd5000;
    localparam logic [CFG_W-1:0] RST_SHORT_MIN = 24'd100000;
    localparam logic [CFG_W-1:0] RST_LONG_MIN  = 24'd1000000;
    localparam logic [CFG_W-1:0] RST_DBL_WIN   = 24'd500000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] short_press_min;
        logic [CFG_W-1:0] long_press_min;
        logic [CFG_W-1:0] double_window;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/bgc_ifs.sv
// Handshake channel interfaces: sample input, gesture output, register writes.
`default_nettype none

interface bgc_sample_if;
    logic                          valid;
    logic                          ready;
    logic                          button_level;
    logic [bgc_pkg::TIME_W-1:0]    sample_time;

    modport source (output valid, output button_level, output sample_time, input ready);
    modport sink   (input valid, input button_level, input sample_time, output ready);
endinterface

interface bgc_gesture_if;
    logic               valid;
    logic               ready;
    bgc_pkg::t_gesture  gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

interface bgc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bgc_pkg::IDX_W-1:0]  index;
    logic [bgc_pkg::CFG_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/bgc_cfg_regs.sv
// Configuration register file for the four timing thresholds.
`default_nettype none

module bgc_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [bgc_pkg::IDX_W-1:0]  i_wr_idx,
    input  wire logic [bgc_pkg::CFG_W-1:0]  i_wr_data,
    output bgc_pkg::t_cfg                   o_cfg
);
    import bgc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= RST_DEBOUNCE;
            r_cfg.short_press_min <= RST_SHORT_MIN;
            r_cfg.long_press_min  <= RST_LONG_MIN;
            r_cfg.double_window   <= RST_DBL_WIN;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_idx))
                CFG_DEBOUNCE:  r_cfg.debounce_time   <= i_wr_data;
                CFG_SHORT_MIN: r_cfg.short_press_min <= i_wr_data;
                CFG_LONG_MIN:  r_cfg.long_press_min  <= i_wr_data;
                CFG_DBL_WIN:   r_cfg.double_window   <= i_wr_data;
                default:       r_cfg.debounce_time   <= r_cfg.debounce_time;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/bgc_core.sv
// Debounce, press timing and tap pairing state with the per-sample classifier.
`default_nettype none

module bgc_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_level,
    input  wire logic [bgc_pkg::TIME_W-1:0]  i_time,
    input  wire bgc_pkg::t_cfg               i_cfg,
    output bgc_pkg::t_gesture                o_gesture
);
    import bgc_pkg::*;

    logic              r_stable;
    logic [TIME_W-1:0] r_last_edge;
    logic [TIME_W-1:0] r_press_start;
    logic [TIME_W-1:0] r_last_rel;
    logic              r_pend;

    logic              n_stable;
    logic [TIME_W-1:0] n_last_edge;
    logic [TIME_W-1:0] n_press_start;
    logic [TIME_W-1:0] n_last_rel;
    logic              n_pend;
    t_gesture          n_gesture;

    logic [TIME_W-1:0] edge_diff;
    logic [TIME_W-1:0] hold_len;
    logic [TIME_W-1:0] rel_diff;
    logic              edge_ok;
    logic              is_long;
    logic              is_tap;
    logic              in_win;
    logic              rel_moved;

    assign edge_diff = i_time - r_last_edge;
    assign hold_len  = i_time - r_press_start;
    assign rel_diff  = i_time - r_last_rel;

    assign edge_ok = (i_level != r_stable) &&
                     (edge_diff >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_time});
    assign is_long = hold_len >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_min};
    assign is_tap  = hold_len >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.short_press_min};
    assign in_win  = rel_diff <= {{(TIME_W-CFG_W){1'b0}}, i_cfg.double_window};

    always_comb begin
        n_stable      = r_stable;
        n_last_edge   = r_last_edge;
        n_press_start = r_press_start;
        n_last_rel    = r_last_rel;
        n_pend        = r_pend;
        n_gesture     = GEST_NONE;
        rel_moved     = 1'b0;

        if (edge_ok) begin
            n_stable    = i_level;
            n_last_edge = i_time;
            if (i_level) begin
                n_press_start = i_time;
            end else begin
                priority if (is_long) begin
                    n_gesture = GEST_LONG;
                    n_pend    = 1'b0;
                end else if (is_tap) begin
                    priority if (!r_pend) begin
                        n_pend     = 1'b1;
                        n_last_rel = i_time;
                        rel_moved  = 1'b1;
                    end else if (in_win) begin
                        n_gesture = GEST_DOUBLE;
                        n_pend    = 1'b0;
                    end else begin
                        // earlier tap reported alone, new tap opens a new window
                        n_gesture  = GEST_SINGLE;
                        n_pend     = 1'b1;
                        n_last_rel = i_time;
                        rel_moved  = 1'b1;
                    end
                end
            end
        end

        // window timeout; a window opened on this sample has zero elapsed time
        if (n_gesture == GEST_NONE && n_pend && !rel_moved && !in_win) begin
            n_gesture = GEST_SINGLE;
            n_pend    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b0;
            r_last_edge   <= '0;
            r_press_start <= '0;
            r_last_rel    <= '0;
            r_pend        <= 1'b0;
        end else if (i_adv) begin
            r_stable      <= n_stable;
            r_last_edge   <= n_last_edge;
            r_press_start <= n_press_start;
            r_last_rel    <= n_last_rel;
            r_pend        <= n_pend;
        end
    end

    assign o_gesture = n_gesture;

endmodule

`default_nettype wire

FILE: sv/button_gesture_classifier_top.sv
// Top level: sample input register, classifier core, gesture output register.
//
//  channel     dir   payload                        word accepted when
//  i_sample    in    button_level, sample_time[63:0] valid && ready
//  o_gesture   out   gesture[1:0]                   valid && ready
//  i_cfg       in    index[1:0], data[23:0]         valid && ready (ready always high)
//
// One sample per clock sustained while the output is not stalled; each sample
// gives exactly one gesture word (GEST_NONE when nothing happened), which the
// classifier core computes from the input register into the output register.
// The classifier state updates in the cycle a sample moves from the input
// register into the output register, so consecutive samples chain correctly.
// A stalled output holds the gesture word; one further sample waits in the
// input register. Synchronous active-low reset restores thresholds and state.
`default_nettype none

module button_gesture_classifier_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    bgc_sample_if.sink     i_sample,
    bgc_gesture_if.source  o_gesture,
    bgc_cfg_if.sink        i_cfg
);
    import bgc_pkg::*;

    logic              r_in_valid;
    logic              r_level;
    logic [TIME_W-1:0] r_time;
    logic              r_out_valid;
    t_gesture          r_gesture;

    logic              adv;
    t_gesture          core_gesture;
    t_cfg              cfg;

    assign adv = r_in_valid && (!r_out_valid || o_gesture.ready);

    assign i_sample.ready = !r_in_valid || adv;
    assign i_cfg.ready    = 1'b1;

    bgc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (cfg)
    );

    bgc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_level   (r_level),
        .i_time    (r_time),
        .i_cfg     (cfg),
        .o_gesture (core_gesture)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_level <= i_sample.button_level;
            r_time  <= i_sample.sample_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_gesture.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gesture <= core_gesture;
        end
    end

    assign o_gesture.valid   = r_out_valid;
    assign o_gesture.gesture = r_gesture;

endmodule

`default_nettype wire

FILE: bench/tb_button_gesture_classifier_top.sv
// Testbench for button_gesture_classifier_top: directed and random sample streams, scoreboard check.
`timescale 1ns / 1ps

module tb_button_gesture_classifier_top;
    import bgc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASE_ITEMS  = 205;
    localparam int unsigned LONG_HOLD_AT = 320;
    localparam int unsigned LONG_HOLD    = 300;

    // Tracks the classifier state and holds the gesture words still due.
    class gesture_scoreboard;
        logic [CFG_W-1:0]  deb_us;
        logic [CFG_W-1:0]  short_us;
        logic [CFG_W-1:0]  long_us;
        logic [CFG_W-1:0]  win_us;
        bit                level_q;
        bit [TIME_W-1:0]   edge_t;
        bit [TIME_W-1:0]   press_t;
        bit [TIME_W-1:0]   release_t;
        bit [1:0]          taps;
        t_gesture          due_gestures[$];
        int                failures;

        function new();
            deb_us    = RST_DEBOUNCE;
            short_us  = RST_SHORT_MIN;
            long_us   = RST_LONG_MIN;
            win_us    = RST_DBL_WIN;
            level_q   = 1'b0;
            edge_t    = '0;
            press_t   = '0;
            release_t = '0;
            taps      = '0;
            failures  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE:  deb_us   = val;
                CFG_SHORT_MIN: short_us = val;
                CFG_LONG_MIN:  long_us  = val;
                CFG_DBL_WIN:   win_us   = val;
                default: ;
            endcase
        endfunction

        function void take_sample(bit lvl, bit [TIME_W-1:0] t);
            bit [TIME_W-1:0] len;
            t_gesture        g;
            g = GEST_NONE;
            if (lvl != level_q && (t - edge_t) >= 64'(deb_us)) begin
                level_q = lvl;
                edge_t  = t;
                if (lvl) begin
                    press_t = t;
                end else begin
                    len = t - press_t;
                    if (len >= 64'(long_us)) begin
                        g    = GEST_LONG;
                        taps = 0;
                    end else if (len >= 64'(short_us)) begin
                        if (taps == 0) begin
                            taps      = 1;
                            release_t = t;
                        end else if ((t - release_t) <= 64'(win_us)) begin
                            g    = GEST_DOUBLE;
                            taps = 0;
                        end else begin
                            // late second tap: report the first, keep the new one pending
                            g         = GEST_SINGLE;
                            taps      = 1;
                            release_t = t;
                        end
                    end
                end
            end
            if (g == GEST_NONE && taps == 1 && (t - release_t) > 64'(win_us)) begin
                g    = GEST_SINGLE;
                taps = 0;
            end
            due_gestures.push_back(g);
        endfunction

        function void check_gesture(logic [1:0] got);
            t_gesture want;
            if (due_gestures.size() == 0) begin
                $error("gesture word %0d arrived with none expected", got);
                failures++;
                return;
            end
            want = due_gestures.pop_front();
            if (got !== want) begin
                $error("gesture mismatch: expected %0d, actual %0d", want, got);
                failures++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bgc_sample_if  smp_if();
    bgc_gesture_if gst_if();
    bgc_cfg_if     cfg_if();

    button_gesture_classifier_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (smp_if),
        .o_gesture (gst_if),
        .i_cfg     (cfg_if)
    );

    gesture_scoreboard sb;
    logic [TIME_W-1:0] t_now;
    int                sent_count = 0;
    bit                no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("button_gesture_classifier_top test failed");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // duration at, just around, or spread about a threshold
    function automatic logic [TIME_W-1:0] near(input logic [CFG_W-1:0] thr);
        logic [TIME_W-1:0] v;
        v = 64'(thr);
        case ($urandom_range(0, 4))
            0:       return (v == 0) ? v : v - 1;
            1:       return v;
            2:       return v + 1;
            3:       return 64'($urandom_range(0, 32'(thr)));
            default: return v + 64'($urandom_range(0, 32'(thr) + 1));
        endcase
    endfunction

    task automatic drive_sample(input bit lvl, input logic [TIME_W-1:0] t);
        int gap;
        gap = no_idle ? 0 : idle_gap();
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.button_level <= lvl;
        smp_if.sample_time  <= t;
        do @(posedge i_clk); while (smp_if.ready !== 1'b1);
        sb.take_sample(lvl, t);
        sent_count++;
    endtask

    task automatic emit(input bit lvl, input logic [TIME_W-1:0] dt);
        t_now = t_now + dt;
        drive_sample(lvl, t_now);
    endtask

    // spend dur at one level with a few repeat samples; next emit lands at the end
    task automatic hold(input bit lvl, input logic [TIME_W-1:0] dur);
        int                fills;
        logic [TIME_W-1:0] step;
        fills = $urandom_range(0, 3);
        step  = dur / 64'(fills + 1);
        repeat (fills) emit(lvl, step);
        t_now = t_now + (dur - step * 64'(fills));
    endtask

    // contact chatter inside the debounce time, always rejected
    task automatic bounce(input bit lvl, output logic [TIME_W-1:0] spent);
        logic [TIME_W-1:0] dt;
        spent = '0;
        if (sb.deb_us > 2 && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                dt = 64'($urandom_range(0, 32'((sb.deb_us - 1) / 2)));
                emit(lvl, dt);
                spent = spent + dt;
            end
        end
    endtask

    task automatic press_cycle();
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] len;
        logic [TIME_W-1:0] spent;
        case ($urandom_range(0, 3))
            0:       gap = near(sb.deb_us);
            1:       gap = near(sb.win_us);
            2:       gap = 64'($urandom_range(0, 2 * 32'(sb.win_us) + 32'(sb.deb_us) + 2));
            default: gap = 64'(sb.deb_us) + 64'($urandom_range(0, 64));
        endcase
        hold(1'b0, gap);
        emit(1'b1, '0);
        bounce(1'b0, spent);
        case ($urandom_range(0, 3))
            0:       len = near(sb.short_us);
            1:       len = near(sb.long_us);
            2:       len = 64'($urandom_range(32'(sb.short_us), 32'(sb.long_us)));
            default: len = near(sb.deb_us);
        endcase
        hold(1'b1, (len > spent) ? len - spent : '0);
        emit(1'b0, '0);
        bounce(1'b1, spent);
    endtask

    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        while (sb.due_gestures.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.set_reg(idx, val);
    endtask

    task automatic program_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] s,
                                      input logic [CFG_W-1:0] l, input logic [CFG_W-1:0] w);
        wait_drained();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_SHORT_MIN, s);
        write_reg(CFG_LONG_MIN, l);
        write_reg(CFG_DBL_WIN, w);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // gesture sink: random back-pressure plus one long hold to fill the pipe
    initial begin
        int stall_left;
        int results_seen;
        bit long_hold_done;
        stall_left     = 0;
        results_seen   = 0;
        long_hold_done = 1'b0;
        gst_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (stall_left == 0) begin
                if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                    stall_left     = LONG_HOLD;
                    long_hold_done = 1'b1;
                end else if (!no_idle) begin
                    stall_left = idle_gap();
                end
            end
            gst_if.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
            @(posedge i_clk);
            if (gst_if.valid === 1'b1 && gst_if.ready === 1'b1) begin
                sb.check_gesture(gst_if.gesture);
                results_seen++;
            end
        end
    end

    initial begin
        int               stop_at;
        logic [CFG_W-1:0] rs;
        logic [CFG_W-1:0] rl;
        sb = new();
        smp_if.valid        <= 1'b0;
        smp_if.button_level <= 1'b0;
        smp_if.sample_time  <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_DEBOUNCE;
        cfg_if.data         <= '0;
        i_rst_n             <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset thresholds
        t_now = '0;
        emit(1'b1, 0);          // press at time zero, inside debounce of reset edge
        emit(1'b0, 10);
        emit(1'b1, 4990);       // exactly at debounce: accepted
        emit(1'b0, 4999);       // chatter, rejected
        emit(1'b0, 145001);     // tap
        emit(1'b1, 200000);
        emit(1'b0, 120000);     // second tap in window: double
        emit(1'b1, 10000);
        emit(1'b0, 99999);      // too short, ignored
        emit(1'b1, 10000);
        emit(1'b0, 100000);     // tap at exact minimum
        emit(1'b0, 500000);     // window boundary, still pending
        emit(1'b0, 1);          // window expired: single
        emit(1'b1, 10000);
        emit(1'b0, 100000);
        emit(1'b1, 400000);
        emit(1'b0, 150000);     // second tap after window: single, new one pending
        emit(1'b1, 10000);
        emit(1'b0, 1000000);    // long over pending tap
        emit(1'b1, 10000);
        emit(1'b0, 999999);     // just below long: tap
        t_now = '1 - 64'd40000;
        emit(1'b0, 0);          // huge elapsed time: single
        emit(1'b1, 40000);      // press at all-ones time
        emit(1'b0, 150000);     // tap across the wrap
        emit(1'b1, 10000);
        emit(1'b0, 100000);     // double across the wrap

        for (int ph = 1; ph <= 7; ph++) begin
            case (ph)
                2: program_thresholds(3, 20, 60, 50);
                3: program_thresholds('0, '0, '0, '0);
                4: program_thresholds('1, '1, '1, '1);
                5: program_thresholds(5, 80, 40, 100);     // long below short
                6: begin
                    rs = CFG_W'($urandom_range(10, 200));
                    rl = CFG_W'($urandom_range(32'(rs), 600));
                    program_thresholds(CFG_W'($urandom_range(0, 50)), rs, rl,
                                       CFG_W'($urandom_range(20, 300)));
                end
                7: program_thresholds(CFG_W'($urandom_range(0, 24'hFFFFFF)),
                                      CFG_W'($urandom_range(0, 24'hFFFFFF)),
                                      CFG_W'($urandom_range(0, 24'hFFFFFF)),
                                      CFG_W'($urandom_range(0, 24'hFFFFFF)));
                default: ;
            endcase
            no_idle = (ph % 3 == 1);
            t_now   = {$urandom, $urandom};
            stop_at = sent_count + PHASE_ITEMS;
            while (sent_count < stop_at) begin
                case ($urandom_range(0, 19))
                    0, 1:    emit(1'($urandom_range(0, 1)),
                                  64'($urandom_range(0, 2 * 32'(sb.deb_us) + 2)));
                    2:       emit(1'($urandom_range(0, 1)), {$urandom, $urandom});
                    default: press_cycle();
                endcase
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.due_gestures.size() != 0) begin
            $error("%0d gesture words never arrived", sb.due_gestures.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("button_gesture_classifier_top test passed");
        else
            $display("button_gesture_classifier_top test failed");
        $finish;
    end

endmodule
